>>> design/ifftbf_pkg.sv
package ifftbf_pkg;

  localparam int IN_W        = 32;
  localparam int OUT_W       = 36;
  localparam int TW_W        = 32;
  localparam int CFG_IDX_W   = 3;
  localparam int PIPE_STAGES = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE    = 3'd0,
    CFG_TW_A_RE = 3'd1,
    CFG_TW_A_IM = 3'd2,
    CFG_TW_B_RE = 3'd3,
    CFG_TW_B_IM = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic signed [IN_W-1:0] in_re0;
    logic signed [IN_W-1:0] in_re1;
    logic signed [IN_W-1:0] in_re2;
    logic signed [IN_W-1:0] in_re3;
    logic signed [IN_W-1:0] in_im0;
    logic signed [IN_W-1:0] in_im1;
    logic signed [IN_W-1:0] in_im2;
    logic signed [IN_W-1:0] in_im3;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] out_re0;
    logic signed [OUT_W-1:0] out_re1;
    logic signed [OUT_W-1:0] out_re2;
    logic signed [OUT_W-1:0] out_re3;
    logic signed [OUT_W-1:0] out_im0;
    logic signed [OUT_W-1:0] out_im1;
    logic signed [OUT_W-1:0] out_im2;
    logic signed [OUT_W-1:0] out_im3;
  } out_item_t;

endpackage

>>> design/ifftbf_stream_if.sv
interface ifftbf_stream_if #(
  parameter type item_t = logic
) ();
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/ifftbf_cmul.sv
module ifftbf_cmul import ifftbf_pkg::*; #(
  parameter int DataW = 33,
  parameter int TwW   = 33,
  parameter int Frac  = 30
) (
  input  logic                    clk_i,
  input  logic [2:0]              en_i,
  input  logic signed [DataW-1:0] dr_i,
  input  logic signed [DataW-1:0] di_i,
  input  logic signed [TwW-1:0]   tr_i,
  input  logic signed [TwW-1:0]   ti_i,
  output logic signed [OUT_W-1:0] re_o,
  output logic signed [OUT_W-1:0] im_o
);

  localparam int LoW = DataW / 2;
  localparam int HiW = DataW - LoW;
  localparam int PhW = HiW + TwW;
  localparam int PlW = LoW + 1 + TwW;
  localparam int PW  = DataW + TwW + 1;
  localparam int RW  = PW + 1;

  localparam logic signed [RW-1:0] Rnd    = RW'(1) << (Frac - 1);
  localparam logic signed [RW-1:0] SatMax = RW'({1'b0, {(OUT_W-1){1'b1}}});
  localparam logic signed [RW-1:0] SatMin = -SatMax - RW'(1);

  function automatic logic signed [OUT_W-1:0] round_sat(input logic signed [PW-1:0] v);
    logic signed [RW-1:0] t;
    t = (RW'(v) + Rnd) >>> Frac;
    if (t > SatMax) begin
      t = SatMax;
    end else if (t < SatMin) begin
      t = SatMin;
    end
    return t[OUT_W-1:0];
  endfunction

  logic signed [HiW-1:0] dr_h, di_h;
  logic signed [LoW:0]   dr_l, di_l;

  logic signed [PhW-1:0] ph_q [4];
  logic signed [PlW-1:0] pl_q [4];
  logic signed [PW-1:0]  prod [4];
  logic signed [PW-1:0]  re_d, im_d, re_q, im_q;
  logic signed [OUT_W-1:0] re_out_q, im_out_q;

  assign dr_h = dr_i[DataW-1:LoW];
  assign di_h = di_i[DataW-1:LoW];
  assign dr_l = {1'b0, dr_i[LoW-1:0]};
  assign di_l = {1'b0, di_i[LoW-1:0]};

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      ph_q[0] <= dr_h * tr_i;
      pl_q[0] <= dr_l * tr_i;
      ph_q[1] <= di_h * ti_i;
      pl_q[1] <= di_l * ti_i;
      ph_q[2] <= di_h * tr_i;
      pl_q[2] <= di_l * tr_i;
      ph_q[3] <= dr_h * ti_i;
      pl_q[3] <= dr_l * ti_i;
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      prod[k] = (PW'(ph_q[k]) <<< LoW) + PW'(pl_q[k]);
    end
    re_d = prod[0] - prod[1];
    im_d = prod[2] + prod[3];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      re_q <= re_d;
      im_q <= im_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      re_out_q <= round_sat(re_q);
      im_out_q <= round_sat(im_q);
    end
  end

  assign re_o = re_out_q;
  assign im_o = im_out_q;

endmodule

>>> design/inverse_fft_two_layer_butterfly.sv
// Two-layer inverse FFT butterfly over four complex samples x0..x3.
// Input channel in_i carries one item of four complex samples (32-bit parts);
// output channel out_o carries one item of four complex results (36-bit parts).
// Both use valid/ready; an item moves on a clock edge with valid and ready high.
// Mode 1: out0 = y0+y2, out1 = y1+y3, out2 = (y0-y2)*b, out3 = (y1-y3)*b, with
// y0 = x0+x1, y1 = (x0-x1)*a, y2 = x2+x3, y3 = (x2-x3)*(-i*a). Mode 0: out0 = y0,
// out1 = y1, out2 = out3 = 0. Products round half up and saturate to 36 bits.
// Twiddles and mode are written through cfg_we_i/cfg_idx_i/cfg_wdata_i only while
// idle, a user duty the block does not enforce. Each layer has one add stage and a
// three-stage complex multiplier (split partial products, product sum, round and
// saturate). Throughput is one item per cycle; every stage holds a valid bit and
// loads when it is empty or its successor loads, so a stalled receiver fills bubbles
// first and in_i.ready drops only once all 8 stages hold items. Nothing is lost or
// repeated. Reset empties the pipeline and sets mode 1 and both twiddles to 1.0.
module inverse_fft_two_layer_butterfly import ifftbf_pkg::*; #(
  parameter int SAMPLE_WIDTH          = 32,
  parameter int TWIDDLE_FRACTION_BITS = 30
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  ifftbf_stream_if.sink        in_i,
  ifftbf_stream_if.source      out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [TW_W-1:0]      cfg_wdata_i
);

  localparam int SmpW   = (SAMPLE_WIDTH < IN_W) ? SAMPLE_WIDTH : IN_W;
  localparam int SExtSh = IN_W - SmpW;
  localparam int D1W    = IN_W + 1;
  localparam int D2W    = OUT_W + 1;
  localparam int TwxW   = TW_W + 1;
  localparam int StgMa  = 1;
  localparam int StgL2  = 4;
  localparam int StgMb  = 5;

  localparam logic [63:0]     OneTwWide = 64'd1 << TWIDDLE_FRACTION_BITS;
  localparam logic [TW_W-1:0] OneTw     = OneTwWide[TW_W-1:0];

  typedef struct packed {
    logic signed [OUT_W-1:0] re;
    logic signed [OUT_W-1:0] im;
  } cpx_t;

  function automatic logic signed [IN_W-1:0] sext_in(input logic [IN_W-1:0] v);
    logic signed [IN_W-1:0] t;
    t = signed'(v << SExtSh);
    return t >>> SExtSh;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_sum(input logic signed [D2W-1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v[D2W-1] != v[D2W-2]) begin
      r = v[D2W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

  logic                   mode_q;
  logic signed [TW_W-1:0] tw_a_re_q, tw_a_im_q, tw_b_re_q, tw_b_im_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= 1'b1;
      tw_a_re_q <= OneTw;
      tw_a_im_q <= '0;
      tw_b_re_q <= OneTw;
      tw_b_im_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_MODE:    mode_q    <= cfg_wdata_i[0];
        CFG_TW_A_RE: tw_a_re_q <= cfg_wdata_i;
        CFG_TW_A_IM: tw_a_im_q <= cfg_wdata_i;
        CFG_TW_B_RE: tw_b_re_q <= cfg_wdata_i;
        CFG_TW_B_IM: tw_b_im_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic [PIPE_STAGES-1:0] vld_q, en;

  always_comb begin
    en[PIPE_STAGES-1] = !vld_q[PIPE_STAGES-1] || out_o.ready;
    for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_i.valid;
      end
      for (int k = 1; k < PIPE_STAGES; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign in_i.ready  = en[0];
  assign out_o.valid = vld_q[PIPE_STAGES-1];

  // layer one sums and differences
  logic signed [IN_W-1:0] xr [4];
  logic signed [IN_W-1:0] xi [4];

  assign xr[0] = sext_in(in_i.data.in_re0);
  assign xr[1] = sext_in(in_i.data.in_re1);
  assign xr[2] = sext_in(in_i.data.in_re2);
  assign xr[3] = sext_in(in_i.data.in_re3);
  assign xi[0] = sext_in(in_i.data.in_im0);
  assign xi[1] = sext_in(in_i.data.in_im1);
  assign xi[2] = sext_in(in_i.data.in_im2);
  assign xi[3] = sext_in(in_i.data.in_im3);

  cpx_t                  y0_q, y2_q;
  logic signed [D1W-1:0] d01_re_q, d01_im_q, d23_re_q, d23_im_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      y0_q.re  <= OUT_W'(D1W'(xr[0]) + D1W'(xr[1]));
      y0_q.im  <= OUT_W'(D1W'(xi[0]) + D1W'(xi[1]));
      y2_q.re  <= OUT_W'(D1W'(xr[2]) + D1W'(xr[3]));
      y2_q.im  <= OUT_W'(D1W'(xi[2]) + D1W'(xi[3]));
      d01_re_q <= D1W'(xr[0]) - D1W'(xr[1]);
      d01_im_q <= D1W'(xi[0]) - D1W'(xi[1]);
      d23_re_q <= D1W'(xr[2]) - D1W'(xr[3]);
      d23_im_q <= D1W'(xi[2]) - D1W'(xi[3]);
    end
  end

  logic signed [TwxW-1:0] a_re_x, a_im_x, a_re_neg_x, b_re_x, b_im_x;

  assign a_re_x     = TwxW'(tw_a_re_q);
  assign a_im_x     = TwxW'(tw_a_im_q);
  assign a_re_neg_x = -a_re_x;
  assign b_re_x     = TwxW'(tw_b_re_q);
  assign b_im_x     = TwxW'(tw_b_im_q);

  cpx_t y1, y3;

  ifftbf_cmul #(
    .DataW (D1W),
    .TwW   (TwxW),
    .Frac  (TWIDDLE_FRACTION_BITS)
  ) u_mul_a1 (
    .clk_i (clk_i),
    .en_i  (en[StgMa +: 3]),
    .dr_i  (d01_re_q),
    .di_i  (d01_im_q),
    .tr_i  (a_re_x),
    .ti_i  (a_im_x),
    .re_o  (y1.re),
    .im_o  (y1.im)
  );

  ifftbf_cmul #(
    .DataW (D1W),
    .TwW   (TwxW),
    .Frac  (TWIDDLE_FRACTION_BITS)
  ) u_mul_a3 (
    .clk_i (clk_i),
    .en_i  (en[StgMa +: 3]),
    .dr_i  (d23_re_q),
    .di_i  (d23_im_q),
    .tr_i  (a_im_x),
    .ti_i  (a_re_neg_x),
    .re_o  (y3.re),
    .im_o  (y3.im)
  );

  cpx_t y0_dly_q [3];
  cpx_t y2_dly_q [3];

  always_ff @(posedge clk_i) begin
    if (en[StgMa]) begin
      y0_dly_q[0] <= y0_q;
      y2_dly_q[0] <= y2_q;
    end
    for (int k = 1; k < 3; k++) begin
      if (en[StgMa+k]) begin
        y0_dly_q[k] <= y0_dly_q[k-1];
        y2_dly_q[k] <= y2_dly_q[k-1];
      end
    end
  end

  // layer two sums and differences
  cpx_t                  y0, y2, z0_d, z1_d, z0_q, z1_q;
  logic signed [D2W-1:0] e02_re_q, e02_im_q, e13_re_q, e13_im_q;
  logic                  two_q;

  assign y0 = y0_dly_q[2];
  assign y2 = y2_dly_q[2];

  always_comb begin
    if (mode_q) begin
      z0_d.re = sat_sum(D2W'(y0.re) + D2W'(y2.re));
      z0_d.im = sat_sum(D2W'(y0.im) + D2W'(y2.im));
      z1_d.re = sat_sum(D2W'(y1.re) + D2W'(y3.re));
      z1_d.im = sat_sum(D2W'(y1.im) + D2W'(y3.im));
    end else begin
      z0_d = y0;
      z1_d = y1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[StgL2]) begin
      z0_q     <= z0_d;
      z1_q     <= z1_d;
      two_q    <= mode_q;
      e02_re_q <= D2W'(y0.re) - D2W'(y2.re);
      e02_im_q <= D2W'(y0.im) - D2W'(y2.im);
      e13_re_q <= D2W'(y1.re) - D2W'(y3.re);
      e13_im_q <= D2W'(y1.im) - D2W'(y3.im);
    end
  end

  cpx_t z2, z3;

  ifftbf_cmul #(
    .DataW (D2W),
    .TwW   (TwxW),
    .Frac  (TWIDDLE_FRACTION_BITS)
  ) u_mul_b2 (
    .clk_i (clk_i),
    .en_i  (en[StgMb +: 3]),
    .dr_i  (e02_re_q),
    .di_i  (e02_im_q),
    .tr_i  (b_re_x),
    .ti_i  (b_im_x),
    .re_o  (z2.re),
    .im_o  (z2.im)
  );

  ifftbf_cmul #(
    .DataW (D2W),
    .TwW   (TwxW),
    .Frac  (TWIDDLE_FRACTION_BITS)
  ) u_mul_b3 (
    .clk_i (clk_i),
    .en_i  (en[StgMb +: 3]),
    .dr_i  (e13_re_q),
    .di_i  (e13_im_q),
    .tr_i  (b_re_x),
    .ti_i  (b_im_x),
    .re_o  (z3.re),
    .im_o  (z3.im)
  );

  cpx_t z0_dly_q [3];
  cpx_t z1_dly_q [3];
  logic two_dly_q [3];

  always_ff @(posedge clk_i) begin
    if (en[StgMb]) begin
      z0_dly_q[0]  <= z0_q;
      z1_dly_q[0]  <= z1_q;
      two_dly_q[0] <= two_q;
    end
    for (int k = 1; k < 3; k++) begin
      if (en[StgMb+k]) begin
        z0_dly_q[k]  <= z0_dly_q[k-1];
        z1_dly_q[k]  <= z1_dly_q[k-1];
        two_dly_q[k] <= two_dly_q[k-1];
      end
    end
  end

  out_item_t out_item;

  always_comb begin
    out_item.out_re0 = z0_dly_q[2].re;
    out_item.out_im0 = z0_dly_q[2].im;
    out_item.out_re1 = z1_dly_q[2].re;
    out_item.out_im1 = z1_dly_q[2].im;
    if (two_dly_q[2]) begin
      out_item.out_re2 = z2.re;
      out_item.out_im2 = z2.im;
      out_item.out_re3 = z3.re;
      out_item.out_im3 = z3.im;
    end else begin
      out_item.out_re2 = '0;
      out_item.out_im2 = '0;
      out_item.out_re3 = '0;
      out_item.out_im3 = '0;
    end
  end

  assign out_o.data = out_item;

endmodule

>>> design/ifftbf_checker.sv
module ifftbf_checker import ifftbf_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input out_item_t            out_data_i,
  input logic                 cfg_we_i,
  input logic [CFG_IDX_W-1:0] cfg_idx_i,
  input logic [TW_W-1:0]      cfg_wdata_i
);

  localparam int CntW = $clog2(PIPE_STAGES + 1);

  logic            mode_q;
  logic [CntW-1:0] cnt_q;
  logic            in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
      cnt_q  <= '0;
    end else begin
      if (cfg_we_i && cfg_reg_e'(cfg_idx_i) == CFG_MODE) begin
        mode_q <= cfg_wdata_i[0];
      end
      if (in_acc && !out_acc) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (!in_acc && out_acc) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_data_i))
    else $error("result item changed while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> cnt_q != '0)
    else $error("result item without an accepted input item");

  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(PIPE_STAGES))
    else $error("more items in flight than pipeline stages");

  a_mode0_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !mode_q |-> out_data_i.out_re2 == '0 && out_data_i.out_im2 == '0 &&
                               out_data_i.out_re3 == '0 && out_data_i.out_im3 == '0)
    else $error("upper results nonzero in single-step mode");

endmodule

bind inverse_fft_two_layer_butterfly ifftbf_checker u_ifftbf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i),
  .cfg_wdata_i (cfg_wdata_i)
);

>>> dv/inverse_fft_two_layer_butterfly_test.sv
module inverse_fft_two_layer_butterfly_test;
  import ifftbf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 30;
  localparam int NDIR = 16;
  localparam int NPHASE = 10;
  localparam int PHASE_ITEMS = 130;

  localparam longint OUT_MAX = (64'sd1 <<< (OUT_W - 1)) - 1;
  localparam longint OUT_MIN = -OUT_MAX - 1;

  localparam logic signed [IN_W-1:0] MAXS = 32'sh7fff_ffff;
  localparam logic signed [IN_W-1:0] MINS = 32'sh8000_0000;

  typedef struct packed {
    logic                   mode;
    logic signed [TW_W-1:0] ar;
    logic signed [TW_W-1:0] ai;
    logic signed [TW_W-1:0] br;
    logic signed [TW_W-1:0] bi;
  } cfg_t;

  typedef struct packed {
    cfg_t      cfg;
    in_item_t  x;
    logic      typed;
    out_item_t y;
  } step_t;

  localparam cfg_t CFG_RST  = '{1'b1, 32'sh4000_0000, 32'sh0, 32'sh4000_0000, 32'sh0};
  localparam cfg_t CFG_M0   = '{1'b0, 32'sh4000_0000, 32'sh0, 32'sh4000_0000, 32'sh0};
  localparam cfg_t CFG_HALF = '{1'b1, 32'sh2000_0000, 32'sh2000_0000,
                                32'sh2000_0000, 32'sh0};
  localparam cfg_t CFG_NEG  = '{1'b1, 32'shc000_0000, 32'sh4000_0000,
                                32'sh4000_0000, 32'shc000_0000};
  localparam cfg_t CFG_BIG  = '{1'b1, 32'sh8000_0000, 32'sh8000_0000,
                                32'sh8000_0000, 32'sh8000_0000};
  localparam cfg_t CFG_BIG2 = '{1'b1, 32'sh7fff_ffff, 32'sh8000_0000,
                                32'sh8000_0000, 32'sh7fff_ffff};
  localparam cfg_t CFG_BIG0 = '{1'b0, 32'sh8000_0000, 32'sh7fff_ffff,
                                32'sh4000_0000, 32'sh0};

  localparam step_t DIR_TBL [NDIR] = '{
    '{CFG_RST, '0, 1'b1, '0},
    '{CFG_RST, '{MAXS, MAXS, MAXS, MAXS, MAXS, MAXS, MAXS, MAXS}, 1'b1,
      '{36'sd8589934588, 0, 0, 0, 36'sd8589934588, 0, 0, 0}},
    '{CFG_RST, '{MINS, MINS, MINS, MINS, MINS, MINS, MINS, MINS}, 1'b1,
      '{-36'sd8589934592, 0, 0, 0, -36'sd8589934592, 0, 0, 0}},
    '{CFG_RST, '{MAXS, MINS, MINS, MAXS, MINS, MAXS, MAXS, MINS}, 1'b0, '0},
    '{CFG_RST, '{32'sd1, -32'sd1, 32'sd3, -32'sd5, -32'sd7, 32'sd2, 32'sd0, 32'sd11},
      1'b0, '0},
    '{CFG_M0, '{MAXS, MAXS, MAXS, MAXS, MAXS, MAXS, MAXS, MAXS}, 1'b1,
      '{36'sd4294967294, 0, 0, 0, 36'sd4294967294, 0, 0, 0}},
    '{CFG_M0, '{MAXS, MINS, 32'sd0, 32'sd0, MAXS, MINS, 32'sd0, 32'sd0}, 1'b1,
      '{-36'sd1, 36'sd4294967295, 0, 0, -36'sd1, 36'sd4294967295, 0, 0}},
    '{CFG_M0, '{MINS, MAXS, MAXS, MAXS, 32'sd5, -32'sd9, MINS, MAXS}, 1'b0, '0},
    '{CFG_HALF, '{32'sd1, 32'sd0, 32'sd0, 32'sd0, -32'sd1, 32'sd0, 32'sd0, 32'sd0},
      1'b0, '0},
    '{CFG_HALF, '{32'sd0, 32'sd1, 32'sd2, 32'sd3, 32'sd3, 32'sd2, 32'sd1, 32'sd0},
      1'b0, '0},
    '{CFG_NEG, '{MAXS, MINS, MINS, MAXS, MINS, MAXS, MAXS, MINS}, 1'b0, '0},
    '{CFG_NEG, '{MINS, MINS, MINS, MINS, MINS, MINS, MINS, MINS}, 1'b0, '0},
    '{CFG_BIG, '{MAXS, MINS, MINS, MAXS, MINS, MAXS, MAXS, MINS}, 1'b0, '0},
    '{CFG_BIG, '{MAXS, MINS, MAXS, MINS, MAXS, MINS, MAXS, MINS}, 1'b0, '0},
    '{CFG_BIG2, '{MAXS, MINS, MINS, MAXS, MINS, MAXS, MAXS, MINS}, 1'b0, '0},
    '{CFG_BIG0, '{MAXS, MINS, MINS, MAXS, MINS, MAXS, MAXS, MINS}, 1'b0, '0}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [TW_W-1:0]      cfg_wdata_i;

  ifftbf_stream_if #(.item_t(in_item_t))  in_if ();
  ifftbf_stream_if #(.item_t(out_item_t)) out_if ();

  inverse_fft_two_layer_butterfly #(
    .SAMPLE_WIDTH         (IN_W),
    .TWIDDLE_FRACTION_BITS(FRAC)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  cfg_t      cur_cfg = CFG_RST;
  out_item_t pending_out [$];
  int        n_fail = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;

  logic [7:0][OUT_W-1:0] got_f;
  logic [7:0][OUT_W-1:0] want_f;
  string field_names [8] = '{"out_re0", "out_re1", "out_re2", "out_re3",
                             "out_im0", "out_im1", "out_im2", "out_im3"};

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint clip36(longint v);
    if (v > OUT_MAX) return OUT_MAX;
    if (v < OUT_MIN) return OUT_MIN;
    return v;
  endfunction

  // round(a*b + c*d) half up at FRAC bits, then clip
  function automatic longint mul_round(longint a, longint b, longint c, longint d);
    logic signed [95:0] wa, wb, wc, wd, acc;
    wa = a;
    wb = b;
    wc = c;
    wd = d;
    acc = wa * wb + wc * wd + (96'sd1 <<< (FRAC - 1));
    acc = acc >>> FRAC;
    if (acc > OUT_MAX) return OUT_MAX;
    if (acc < OUT_MIN) return OUT_MIN;
    return longint'(acc);
  endfunction

  function automatic void cmul(input longint dr, input longint di, input longint tr,
                               input longint ti, output longint pr, output longint pi);
    pr = mul_round(dr, tr, -di, ti);
    pi = mul_round(di, tr, dr, ti);
  endfunction

  function automatic out_item_t ifft_bfly(in_item_t x);
    longint xr [4], xi [4], yr [4], yi [4], zr [4], zi [4];
    longint ar, ai, br, bi;
    out_item_t o;
    ar = cur_cfg.ar;
    ai = cur_cfg.ai;
    br = cur_cfg.br;
    bi = cur_cfg.bi;
    xr[0] = x.in_re0; xr[1] = x.in_re1; xr[2] = x.in_re2; xr[3] = x.in_re3;
    xi[0] = x.in_im0; xi[1] = x.in_im1; xi[2] = x.in_im2; xi[3] = x.in_im3;
    yr[0] = clip36(xr[0] + xr[1]);
    yi[0] = clip36(xi[0] + xi[1]);
    cmul(xr[0] - xr[1], xi[0] - xi[1], ar, ai, yr[1], yi[1]);
    yr[2] = clip36(xr[2] + xr[3]);
    yi[2] = clip36(xi[2] + xi[3]);
    cmul(xr[2] - xr[3], xi[2] - xi[3], ai, -ar, yr[3], yi[3]);
    if (!cur_cfg.mode) begin
      zr[0] = yr[0]; zi[0] = yi[0];
      zr[1] = yr[1]; zi[1] = yi[1];
      zr[2] = 0; zi[2] = 0;
      zr[3] = 0; zi[3] = 0;
    end else begin
      zr[0] = clip36(yr[0] + yr[2]);
      zi[0] = clip36(yi[0] + yi[2]);
      zr[1] = clip36(yr[1] + yr[3]);
      zi[1] = clip36(yi[1] + yi[3]);
      cmul(yr[0] - yr[2], yi[0] - yi[2], br, bi, zr[2], zi[2]);
      cmul(yr[1] - yr[3], yi[1] - yi[3], br, bi, zr[3], zi[3]);
    end
    o.out_re0 = zr[0][OUT_W-1:0]; o.out_im0 = zi[0][OUT_W-1:0];
    o.out_re1 = zr[1][OUT_W-1:0]; o.out_im1 = zi[1][OUT_W-1:0];
    o.out_re2 = zr[2][OUT_W-1:0]; o.out_im2 = zi[2][OUT_W-1:0];
    o.out_re3 = zr[3][OUT_W-1:0]; o.out_im3 = zi[3][OUT_W-1:0];
    return o;
  endfunction

  function automatic logic signed [TW_W-1:0] rand_twiddle();
    longint v;
    case ($urandom_range(0, 9))
      0: return 32'sh4000_0000;
      1: return 32'shc000_0000;
      2: return 32'sh0;
      3: return $urandom;
      default: begin
        v = longint'($urandom_range(32'h8000_0000, 0)) - 64'sd1073741824;
        return v[TW_W-1:0];
      end
    endcase
  endfunction

  task automatic push_item(in_item_t x, logic typed, out_item_t y);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= x;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    pending_out.push_back(typed ? y : ifft_bfly(x));
  endtask

  // drop valid, wait for every pending item, then let the pipe empty
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_out.size() != 0) @(posedge clk_i);
    repeat (PIPE_STAGES) @(posedge clk_i);
  endtask

  task automatic apply_cfg(cfg_t c);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_MODE;
    cfg_wdata_i <= {{(TW_W-1){1'b0}}, c.mode};
    @(posedge clk_i);
    cfg_idx_i   <= CFG_TW_A_RE;
    cfg_wdata_i <= c.ar;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_TW_A_IM;
    cfg_wdata_i <= c.ai;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_TW_B_RE;
    cfg_wdata_i <= c.br;
    @(posedge clk_i);
    cfg_idx_i   <= CFG_TW_B_IM;
    cfg_wdata_i <= c.bi;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_cfg = c;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_out.size() == 0) begin
        $error("output item with no item pending");
        n_fail++;
      end else begin
        got_f  = out_if.data;
        want_f = pending_out.pop_front();
        for (int i = 0; i < 8; i++) begin
          if (got_f[7-i] !== want_f[7-i]) begin
            $error("%s: expected %0d, got %0d", field_names[i],
                   $signed(want_f[7-i]), $signed(got_f[7-i]));
            n_fail++;
          end
        end
      end
    end
    out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  initial begin
    cfg_t                 c;
    logic [7:0][IN_W-1:0] f;
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_MODE;
    cfg_wdata_i  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NDIR; i++) begin
      if (DIR_TBL[i].cfg != cur_cfg) apply_cfg(DIR_TBL[i].cfg);
      push_item(DIR_TBL[i].x, DIR_TBL[i].typed, DIR_TBL[i].y);
    end

    for (int p = 0; p < NPHASE; p++) begin
      case (p)
        2: c = CFG_NEG;
        3: c = CFG_BIG2;
        7: c = CFG_BIG;
        default: c = '{(p % 3) != 1, rand_twiddle(), rand_twiddle(),
                       rand_twiddle(), rand_twiddle()};
      endcase
      apply_cfg(c);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      repeat (PHASE_ITEMS) begin
        for (int k = 0; k < 8; k++) begin
          case ($urandom_range(0, 9))
            0: f[k] = MAXS;
            1: f[k] = MINS;
            2: f[k] = $urandom_range(0, 16) - 8;
            default: f[k] = $urandom;
          endcase
        end
        push_item(in_item_t'(f), 1'b0, '0);
      end
    end

    settle();
    if (n_fail == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> sim.f
design/ifftbf_pkg.sv
design/ifftbf_stream_if.sv
design/ifftbf_cmul.sv
design/inverse_fft_two_layer_butterfly.sv
design/ifftbf_checker.sv
dv/inverse_fft_two_layer_butterfly_test.sv
